// ===== hw/rtl/kdim_pkg.sv =====
package kdim_pkg;

  localparam int MOM_W   = 24;
  localparam int MASS_W  = 20;
  localparam int OUT_W   = 24;
  localparam int DIFF_W  = MOM_W + 1;

  // Square root sizes: daughter and neutral energy share one size, the mass has its own.
  localparam int EN_ROOT_W   = 25;
  localparam int MASS_ROOT_W = 26;

  localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

  typedef logic signed [MOM_W-1:0] mom_t;
  typedef logic [MASS_W-1:0]       mass_t;
  typedef logic [OUT_W-1:0]        out_mass_t;

endpackage

// ===== hw/rtl/kdim_in_if.sv =====
interface kdim_in_if;
  import kdim_pkg::*;
  logic  valid;
  logic  ready;
  mom_t  parent_px;
  mom_t  parent_py;
  mom_t  parent_pz;
  mom_t  daughter_px;
  mom_t  daughter_py;
  mom_t  daughter_pz;
  mass_t daughter_mass;
  mass_t neutral_mass;

  modport source (
    output valid, parent_px, parent_py, parent_pz,
           daughter_px, daughter_py, daughter_pz, daughter_mass, neutral_mass,
    input  ready
  );
  modport sink (
    input  valid, parent_px, parent_py, parent_pz,
           daughter_px, daughter_py, daughter_pz, daughter_mass, neutral_mass,
    output ready
  );
endinterface

// ===== hw/rtl/kdim_out_if.sv =====
interface kdim_out_if;
  import kdim_pkg::*;
  logic      valid;
  logic      ready;
  out_mass_t inv_mass;
  logic      unphysical;
  logic      saturated;

  modport source (output valid, inv_mass, unphysical, saturated, input ready);
  modport sink (input valid, inv_mass, unphysical, saturated, output ready);
endinterface

// ===== hw/rtl/kdim_sqrt.sv =====
module kdim_sqrt #(
  parameter int ROOT_W = 25,
  parameter int SIDE_W = 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [2*ROOT_W-1:0]   radicand,
  input  logic [SIDE_W-1:0]     side_in,
  output logic                  out_valid,
  output logic [ROOT_W-1:0]     root,
  output logic [SIDE_W-1:0]     side_out
);
  localparam int RAD_W = 2 * ROOT_W;
  localparam int REM_W = ROOT_W + 3;

  logic              vld  [0:ROOT_W];
  logic [RAD_W-1:0]  rad  [0:ROOT_W];
  logic [REM_W-1:0]  rem  [0:ROOT_W];
  logic [ROOT_W-1:0] rt   [0:ROOT_W];
  logic [SIDE_W-1:0] side [0:ROOT_W];

  assign vld[0]  = in_valid;
  assign rad[0]  = radicand;
  assign rem[0]  = '0;
  assign rt[0]   = '0;
  assign side[0] = side_in;

  // One result bit per stage, restoring method; the radicand shifts along two bits a stage.
  for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
    logic [REM_W-1:0] cur;
    logic [REM_W-1:0] tst;
    logic             ge;

    assign cur = {rem[j][REM_W-3:0], rad[j][RAD_W-1 -: 2]};
    assign tst = {1'b0, rt[j], 2'b01};
    assign ge  = (cur >= tst);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else if (en) begin
        vld[j+1] <= vld[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[j+1]  <= ge ? (cur - tst) : cur;
        rt[j+1]   <= {rt[j][ROOT_W-2:0], ge};
        rad[j+1]  <= {rad[j][RAD_W-3:0], 2'b00};
        side[j+1] <= side[j];
      end
    end
  end

  assign out_valid = vld[ROOT_W];
  assign root      = rt[ROOT_W];
  assign side_out  = side[ROOT_W];
endmodule

// ===== hw/rtl/kdim_front.sv =====
module kdim_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_valid,
  input  kdim_pkg::mom_t                  parent_px,
  input  kdim_pkg::mom_t                  parent_py,
  input  kdim_pkg::mom_t                  parent_pz,
  input  kdim_pkg::mom_t                  daughter_px,
  input  kdim_pkg::mom_t                  daughter_py,
  input  kdim_pkg::mom_t                  daughter_pz,
  input  kdim_pkg::mass_t                 daughter_mass,
  input  kdim_pkg::mass_t                 neutral_mass,
  output logic                            out_valid,
  output logic [2*kdim_pkg::MOM_W-1:0]    pd2,
  output logic [2*kdim_pkg::DIFF_W-1:0]   pn2,
  output logic [2*kdim_pkg::MOM_W-1:0]    pp2
);
  import kdim_pkg::*;

  localparam int PSQ_W = 2 * MOM_W;
  localparam int NSQ_W = 2 * DIFF_W;
  localparam int MSQ_W = 2 * MASS_W;

  // Stage A: neutral momentum as parent minus daughter.
  logic                     va;
  mom_t                     pa [0:2];
  mom_t                     da [0:2];
  logic signed [DIFF_W-1:0] na [0:2];
  mass_t                    mda;
  mass_t                    mna;

  // Stage B: all squares.
  logic             vb;
  logic [PSQ_W-1:0] psq [0:2];
  logic [PSQ_W-1:0] dsq [0:2];
  logic [NSQ_W-1:0] nsq [0:2];
  logic [MSQ_W-1:0] mdsq;
  logic [MSQ_W-1:0] mnsq;

  logic             vc;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else if (en) begin
      va <= in_valid;
      vb <= va;
      vc <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa[0] <= parent_px;
      pa[1] <= parent_py;
      pa[2] <= parent_pz;
      da[0] <= daughter_px;
      da[1] <= daughter_py;
      da[2] <= daughter_pz;
      na[0] <= DIFF_W'(parent_px) - DIFF_W'(daughter_px);
      na[1] <= DIFF_W'(parent_py) - DIFF_W'(daughter_py);
      na[2] <= DIFF_W'(parent_pz) - DIFF_W'(daughter_pz);
      mda   <= daughter_mass;
      mna   <= neutral_mass;
    end
  end

  // The products are formed at the full square width so no high bits are lost.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        psq[k] <= $unsigned(PSQ_W'(pa[k] * pa[k]));
        dsq[k] <= $unsigned(PSQ_W'(da[k] * da[k]));
        nsq[k] <= $unsigned(NSQ_W'(na[k] * na[k]));
      end
      mdsq <= mda * mda;
      mnsq <= mna * mna;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pd2 <= dsq[0] + dsq[1] + dsq[2] + PSQ_W'(mdsq);
      pn2 <= nsq[0] + nsq[1] + nsq[2] + NSQ_W'(mnsq);
      pp2 <= psq[0] + psq[1] + psq[2];
    end
  end

  assign out_valid = vc;
endmodule

// ===== hw/rtl/kink_decay_invariant_mass_core.sv =====
// Channel  Dir  Contents
// din      in   parent and daughter momenta, daughter and neutral mass hypotheses
// dout     out  inv_mass, unphysical, saturated
//
// One word is accepted per cycle unless dout stalls; each word passes through the
// difference, square and sum stages, the two energy square roots (25 stages, side
// by side), the energy-sum, square and subtract stages, the mass square root (26
// stages) and the output register.
// Reset clears only the valid bits. The whole pipeline holds while dout waits,
// so din.ready follows dout.ready whenever the output register is full.
module kink_decay_invariant_mass_core (
  input logic     clk,
  input logic     rst,
  kdim_in_if.sink    din,
  kdim_out_if.source dout
);
  import kdim_pkg::*;

  localparam int PSQ_W = 2 * MOM_W;
  localparam int NSQ_W = 2 * DIFF_W;
  localparam int S_W   = MASS_ROOT_W;
  localparam int S2_W  = 2 * S_W;

  logic en;
  assign en        = !dout.valid || dout.ready;
  assign din.ready = en;

  logic             f_valid;
  logic [PSQ_W-1:0] pd2;
  logic [NSQ_W-1:0] pn2;
  logic [PSQ_W-1:0] pp2;

  kdim_front u_front (
    .clk           (clk),
    .rst           (rst),
    .en            (en),
    .in_valid      (din.valid),
    .parent_px     (din.parent_px),
    .parent_py     (din.parent_py),
    .parent_pz     (din.parent_pz),
    .daughter_px   (din.daughter_px),
    .daughter_py   (din.daughter_py),
    .daughter_pz   (din.daughter_pz),
    .daughter_mass (din.daughter_mass),
    .neutral_mass  (din.neutral_mass),
    .out_valid     (f_valid),
    .pd2           (pd2),
    .pn2           (pn2),
    .pp2           (pp2)
  );

  logic                 ed_valid;
  logic [EN_ROOT_W-1:0] e_d;
  logic [PSQ_W-1:0]     pp2_d;
  logic                 en_valid;
  logic [EN_ROOT_W-1:0] e_n;
  logic                 unused_side;

  kdim_sqrt #(.ROOT_W(EN_ROOT_W), .SIDE_W(PSQ_W)) u_sqrt_ed (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_valid),
    .radicand  ((2*EN_ROOT_W)'(pd2)),
    .side_in   (pp2),
    .out_valid (ed_valid),
    .root      (e_d),
    .side_out  (pp2_d)
  );

  kdim_sqrt #(.ROOT_W(EN_ROOT_W), .SIDE_W(1)) u_sqrt_en (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_valid),
    .radicand  ((2*EN_ROOT_W)'(pn2)),
    .side_in   (1'b0),
    .out_valid (en_valid),
    .root      (e_n),
    .side_out  (unused_side)
  );

  // Energy sum, its square, then the signed mass squared.
  logic                   vs;
  logic                   vs2;
  logic                   vm;
  logic [S_W-1:0]         s;
  logic [PSQ_W-1:0]       pp2_s;
  logic [S2_W-1:0]        s2;
  logic [PSQ_W-1:0]       pp2_s2;
  logic signed [S2_W:0]   msq;
  logic [S2_W-1:0]        m_rad;
  logic                   m_unphys;

  assign msq = $signed({1'b0, s2}) - $signed((S2_W+1)'(pp2_s2));

  always_ff @(posedge clk) begin
    if (rst) begin
      vs  <= 1'b0;
      vs2 <= 1'b0;
      vm  <= 1'b0;
    end else if (en) begin
      vs  <= ed_valid && en_valid && !unused_side;
      vs2 <= vs;
      vm  <= vs2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s        <= S_W'(e_d) + S_W'(e_n);
      pp2_s    <= pp2_d;
      s2       <= s * s;
      pp2_s2   <= pp2_s;
      m_unphys <= (msq <= 0);
      m_rad    <= (msq <= 0) ? '0 : msq[S2_W-1:0];
    end
  end

  logic                   mv;
  logic [MASS_ROOT_W-1:0] mass;
  logic                   mass_unphys;

  kdim_sqrt #(.ROOT_W(MASS_ROOT_W), .SIDE_W(1)) u_sqrt_mass (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vm),
    .radicand  (m_rad),
    .side_in   (m_unphys),
    .out_valid (mv),
    .root      (mass),
    .side_out  (mass_unphys)
  );

  logic sat;
  assign sat = (mass[MASS_ROOT_W-1:OUT_W] != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout.valid <= mv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout.inv_mass   <= sat ? OUT_MAX : mass[OUT_W-1:0];
      dout.unphysical <= mass_unphys;
      dout.saturated  <= sat;
    end
  end
endmodule

// ===== tb/tb_kink_decay_invariant_mass_core.sv =====
module tb_kink_decay_invariant_mass_core;
  timeunit 1ns;
  timeprecision 1ps;
  import kdim_pkg::*;

  localparam int LATENCY    = 58;
  localparam int IDLE_LIMIT = 5000;
  localparam int N_RANDOM   = 1060;

  typedef struct packed {
    out_mass_t mass;
    logic      unphys;
    logic      sat;
  } mass_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  kdim_in_if  din ();
  kdim_out_if dout ();

  kink_decay_invariant_mass_core DUT (.clk(clk), .rst(rst), .din(din), .dout(dout));

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  mass_result_t expected_masses[$];
  int errors     = 0;
  int idle_count = 0;
  int stall_left = 0;
  int hold_left  = 0;
  bit rx_steady  = 1'b0;
  bit tx_steady  = 1'b0;

  function automatic logic [63:0] floor_root(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] digit;
    rem   = v;
    root  = 64'd0;
    digit = 64'd1 << 62;
    while (digit > rem) digit = digit >> 2;
    while (digit != 64'd0) begin
      if (rem >= root + digit) begin
        rem  = rem - (root + digit);
        root = (root >> 1) + digit;
      end else begin
        root = root >> 1;
      end
      digit = digit >> 2;
    end
    return root;
  endfunction

  function automatic mass_result_t predict_mass(input mom_t px, py, pz, dx, dy, dz,
                                                input mass_t md, mn);
    longint ipx, ipy, ipz, idx, idy, idz, nx, ny, nz, e_d, e_n, s, msq;
    mass_result_t r;
    logic [63:0] m;
    ipx = px; ipy = py; ipz = pz;
    idx = dx; idy = dy; idz = dz;
    nx = ipx - idx; ny = ipy - idy; nz = ipz - idz;
    e_d = floor_root(idx*idx + idy*idy + idz*idz + longint'(md)*longint'(md));
    e_n = floor_root(nx*nx + ny*ny + nz*nz + longint'(mn)*longint'(mn));
    s   = e_d + e_n;
    msq = s*s - (ipx*ipx + ipy*ipy + ipz*ipz);
    r = '0;
    if (msq <= 0) begin
      r.unphys = 1'b1;
    end else begin
      m = floor_root(msq);
      if (m > 64'(OUT_MAX)) begin
        r.mass = OUT_MAX;
        r.sat  = 1'b1;
      end else begin
        r.mass = m[OUT_W-1:0];
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    errors++;
  endtask

  // Output side: check each word and draw the stall before the next one.
  always @(posedge clk) begin
    mass_result_t want;
    if (!rst && dout.valid && dout.ready) begin
      if (expected_masses.size() == 0) begin
        report_mismatch($sformatf("unexpected word mass=%0d", dout.inv_mass));
      end else begin
        want = expected_masses.pop_front();
        if (dout.inv_mass !== want.mass)
          report_mismatch($sformatf("inv_mass %0d, expected %0d", dout.inv_mass, want.mass));
        if (dout.unphysical !== want.unphys)
          report_mismatch($sformatf("unphysical %b, expected %b", dout.unphysical, want.unphys));
        if (dout.saturated !== want.sat)
          report_mismatch($sformatf("saturated %b, expected %b", dout.saturated, want.sat));
      end
      stall_left = rx_steady ? 0 : $urandom_range(0, 15);
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      dout.ready = 1'b0;
    end else if (hold_left > 0) begin
      dout.ready = 1'b0;
      hold_left--;
    end else if (stall_left > 0) begin
      dout.ready = 1'b0;
      stall_left--;
    end else begin
      dout.ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((din.valid && din.ready) || (dout.valid && dout.ready) || rst) begin
      idle_count = 0;
    end else if (++idle_count >= IDLE_LIMIT) begin
      $display("Timeout: no word moved for %0d cycles", IDLE_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_word(input mom_t px, py, pz, dx, dy, dz, input mass_t md, mn);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 15);
    repeat (gap) begin
      @(negedge clk);
      din.valid = 1'b0;
    end
    @(negedge clk);
    din.valid       = 1'b1;
    din.parent_px   = px;
    din.parent_py   = py;
    din.parent_pz   = pz;
    din.daughter_px = dx;
    din.daughter_py = dy;
    din.daughter_pz = dz;
    din.daughter_mass = md;
    din.neutral_mass  = mn;
    do @(posedge clk); while (!din.ready);
    expected_masses.push_back(predict_mass(px, py, pz, dx, dy, dz, md, mn));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    din.valid = 1'b0;
    while (expected_masses.size() != 0) @(posedge clk);
  endtask

  function automatic mom_t rand_mom(input int span);
    return mom_t'($signed($urandom_range(0, 2*span)) - span);
  endfunction

  task automatic test_directed();
    mom_t big;
    mom_t neg;
    big = mom_t'(24'h7FFFFF);
    neg = mom_t'(24'h800000);
    send_word(0, 0, 0, 0, 0, 0, 0, 0);
    send_word(big, big, big, big, big, big, '1, '1);
    send_word(neg, neg, neg, neg, neg, neg, '1, '1);
    send_word(big, neg, big, neg, big, neg, '1, '1);
    send_word(neg, big, neg, big, neg, big, 0, 0);
    send_word(0, 0, 0, neg, 0, 0, 0, 0);
    send_word(0, 0, 0, neg, neg, neg, '1, '1);
    send_word(0, 0, 0, 0, 0, 0, '1, '1);
    send_word(0, 0, 0, 0, 0, 0, 20'h10000, 0);
    // Collinear massless daughters give a mass squared of zero, which is flagged unphysical.
    send_word(24'sh60000, 0, 0, 24'sh30000, 0, 0, 0, 0);
    send_word(24'sh12345, 24'sh23456, -24'sh11111, 24'sh091A2, 24'sh11A2B, -24'sh08888, 0, 0);
    send_word(24'sh10000, 24'sh10000, 24'sh10000, 24'sh10000, 24'sh10000, 24'sh10000, 0, 0);
    send_word(24'sh20000, 0, 0, 0, 0, 0, 20'h09F00, 20'h08000);
    send_word(big, 0, 0, neg, 0, 0, '1, 0);
    send_word(1, -1, 1, -1, 1, -1, 1, 1);
    send_word(-24'sh10000, 24'sh8000, 0, 24'sh4000, -24'sh2000, 24'sh1000, 20'h023BB, 20'h08A3D);
    wait_drained();
  endtask

  task automatic test_random();
    int kind;
    mom_t dx, dy, dz;
    for (int i = 0; i < N_RANDOM; i++) begin
      kind = $urandom_range(0, 3);
      dx = rand_mom(kind == 0 ? 8388607 : 24'h40000);
      dy = rand_mom(kind == 0 ? 8388607 : 24'h40000);
      dz = rand_mom(kind == 0 ? 8388607 : 24'h40000);
      if (kind == 0)
        send_word(rand_mom(8388607), rand_mom(8388607), rand_mom(8388607),
                  dx, dy, dz, mass_t'($urandom), mass_t'($urandom));
      else if (kind == 3)
        // Parent nearly collinear with the daughter.
        send_word(dx + (dx >>> 1), dy + (dy >>> 1), dz + (dz >>> 1), dx, dy, dz,
                  mass_t'($urandom_range(0, 3)), mass_t'($urandom_range(0, 3)));
      else
        send_word(dx + rand_mom(24'h40000), dy + rand_mom(24'h40000),
                  dz + rand_mom(24'h40000), dx, dy, dz,
                  mass_t'($urandom_range(0, 20'h20000)),
                  mass_t'($urandom_range(0, 20'h20000)));
    end
    wait_drained();
  endtask

  task automatic test_back_pressure();
    tx_steady = 1'b1;
    hold_left = 300;
    for (int i = 0; i < 120; i++)
      send_word(rand_mom(24'h80000), rand_mom(24'h80000), rand_mom(24'h80000),
                rand_mom(24'h80000), rand_mom(24'h80000), rand_mom(24'h80000),
                mass_t'($urandom), mass_t'($urandom));
    wait_drained();
  endtask

  task automatic test_full_rate();
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    for (int i = 0; i < 150; i++)
      send_word(rand_mom(24'h100000), rand_mom(24'h100000), rand_mom(24'h100000),
                rand_mom(24'h100000), rand_mom(24'h100000), rand_mom(24'h100000),
                mass_t'($urandom), mass_t'($urandom));
    wait_drained();
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  initial begin
    din.valid = 1'b0;
    din.parent_px = '0;
    din.parent_py = '0;
    din.parent_pz = '0;
    din.daughter_px = '0;
    din.daughter_py = '0;
    din.daughter_pz = '0;
    din.daughter_mass = '0;
    din.neutral_mass = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_random();
    test_back_pressure();
    test_full_rate();
    repeat (LATENCY + 20) @(posedge clk);
    if (expected_masses.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_masses.size()));
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
